// File: rtl/weighted_nearest_centroid_assign_core_defines.svh
// Assertion macros shared by the weighted nearest-centroid assignment RTL.
// Each macro expects signals named clk and rst_n in the scope that uses it.
`ifndef WEIGHTED_NEAREST_CENTROID_ASSIGN_CORE_DEFINES_SVH
`define WEIGHTED_NEAREST_CENTROID_ASSIGN_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WNCA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WNCA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wnca_pkg.sv
// Shared types and constants for the weighted nearest-centroid assignment core.
// No dependencies; used by wnca_cell and the top level.
package wnca_pkg;

    localparam int DEF_MAX_CLUSTERS = 16;
    localparam int DEF_MAX_FEATURES = 64;

    localparam int OUT_CLUSTERS = 16;
    localparam int IDX_W        = 4;
    localparam int FEAT_W       = 6;
    localparam int VAL_W        = 16;
    localparam int ACC_W        = 48;
    localparam int TERM_W       = 32;
    localparam int COUNT_W      = 5;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    typedef enum logic {
        REQ_LOAD    = 1'b0,
        REQ_FEATURE = 1'b1
    } req_t;

    // One input item as it travels down the row of cells.
    typedef struct packed {
        logic               valid;
        req_t               req_type;
        logic [IDX_W-1:0]   cluster_index;
        logic [FEAT_W-1:0]  feature_index;
        logic [VAL_W-1:0]   value;
        logic [VAL_W-1:0]   weight;
        logic               last_feature;
    } tok_t;

    // Running winner of the nearest-cluster search.
    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   index;
        logic [ACC_W-1:0]   distance;
    } best_t;

endpackage

// File: rtl/wnca_cell.sv
// One cluster cell: local prototype/weight memory, distance pipeline, accumulator
// and one step of the nearest-cluster search. Depends on wnca_pkg and the defines.
`include "weighted_nearest_centroid_assign_core_defines.svh"

module wnca_cell #(
    parameter int CELL         = 0,
    parameter int MAX_FEATURES = wnca_pkg::DEF_MAX_FEATURES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [wnca_pkg::COUNT_W-1:0]  n_active,
    input  wnca_pkg::tok_t                tok_in,
    input  wnca_pkg::best_t               best_in,
    output wnca_pkg::tok_t                tok_out,
    output wnca_pkg::best_t               best_out
);
    import wnca_pkg::*;

    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic [2*VAL_W-1:0] mem [MAX_FEATURES];
    logic [2*VAL_W-1:0] mem_q_reg;

    tok_t               s0_reg;
    logic               ft_ok;
    logic [AW-1:0]      addr;

    logic               s1_valid_reg, s1_last_reg, s1_ok_reg;
    logic [VAL_W-1:0]   s1_value_reg;

    logic               s2_valid_reg, s2_last_reg, s2_ok_reg;
    logic [2*VAL_W-1:0] s2_sq_reg;
    logic [VAL_W-1:0]   s2_weight_reg;

    logic               s3_valid_reg, s3_last_reg;
    logic [TERM_W-1:0]  s3_term_reg;

    logic [ACC_W-1:0]   acc_reg;
    logic               fin_valid_reg;
    logic [ACC_W-1:0]   fin_dist_reg;
    best_t              best_reg, best_next;

    logic [VAL_W:0]     diff, diff_neg;
    logic [VAL_W-1:0]   abs_diff, proto, wt;
    logic [2*VAL_W-1:0] sq;
    logic [ACC_W-1:0]   prod;
    logic [ACC_W:0]     sum_wide;
    logic [ACC_W-1:0]   sum_sat;
    logic               in_use;

    assign tok_out  = s0_reg;
    assign best_out = best_reg;

    assign ft_ok = 32'(s0_reg.feature_index) < MAX_FEATURES;
    assign addr  = ft_ok ? AW'(s0_reg.feature_index) : '0;

    // Stage 0: the item is registered here; loads for this cluster are written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
        end
        else if (advance)
        begin
            s0_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (s0_reg.valid && s0_reg.req_type == REQ_LOAD && ft_ok
                && 32'(s0_reg.cluster_index) == CELL)
            begin
                mem[addr] <= {s0_reg.weight, s0_reg.value};
            end
            mem_q_reg <= mem[addr];
        end
    end

    // Stage 1: absolute difference and its square.
    assign proto    = mem_q_reg[VAL_W-1:0];
    assign wt       = mem_q_reg[2*VAL_W-1:VAL_W];
    assign diff     = {s1_value_reg[VAL_W-1], s1_value_reg} - {proto[VAL_W-1], proto};
    assign diff_neg = ~diff + (VAL_W+1)'(1);
    assign abs_diff = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
    assign sq       = abs_diff * abs_diff;

    // Stage 2: weighting, Q32.16 product truncated to Q32.0.
    assign prod = ACC_W'(s2_sq_reg) * ACC_W'(s2_weight_reg);

    // Stage 3: saturating accumulate.
    assign sum_wide = {1'b0, acc_reg} + (ACC_W+1)'(s3_term_reg);
    assign sum_sat  = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            acc_reg       <= '0;
            best_reg      <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s0_reg.valid && s0_reg.req_type == REQ_FEATURE;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            fin_valid_reg <= s3_valid_reg && s3_last_reg;
            if (s3_valid_reg)
            begin
                acc_reg <= s3_last_reg ? '0 : sum_sat;
            end
            best_reg      <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_last_reg    <= s0_reg.last_feature;
            s1_ok_reg      <= ft_ok;
            s1_value_reg   <= s0_reg.value;
            s2_last_reg    <= s1_last_reg;
            s2_ok_reg      <= s1_ok_reg;
            s2_sq_reg      <= sq;
            s2_weight_reg  <= wt;
            s3_last_reg    <= s2_last_reg;
            s3_term_reg    <= s2_ok_reg ? prod[ACC_W-1:VAL_W] : '0;
            fin_dist_reg   <= sum_sat;
        end
    end

    // Stage 4: compare the finished distance with the winner handed in from the left.
    assign in_use = 32'(n_active) > CELL;

    always_comb
    begin
        best_next       = best_in;
        best_next.valid = fin_valid_reg;
        if (in_use && fin_dist_reg <= best_in.distance)
        begin
            best_next.index    = IDX_W'(CELL);
            best_next.distance = fin_dist_reg;
        end
    end

    `WNCA_ASSERT_NXT(a_acc_clear, advance && s3_valid_reg && s3_last_reg, acc_reg == '0, "accumulator not cleared after the last feature")
    `WNCA_ASSERT_NXT(a_acc_grow, advance && s3_valid_reg && !s3_last_reg, acc_reg >= $past(acc_reg), "accumulator decreased within an object")
    `WNCA_ASSERT_IMP(a_best_align, (CELL != 0) && fin_valid_reg, best_in.valid, "running winner from the left cell is out of step")

endmodule

// File: rtl/weighted_nearest_centroid_assign_core.sv
// Top level of the weighted nearest-centroid assignment core: APB register,
// stream ports, the row of wnca_cell instances and the result register. Uses wnca_pkg.
//
// The core accepts one stream transfer per clock while the row moves, a rate set by
// the single-port memory in each cell. A transfer with tuser = 0 loads the prototype
// coordinate and weight of one (cluster, feature) pair; a transfer with tuser = 1
// carries one feature of an object, and tlast marks the object's final feature. Each
// transfer walks down a row of MAX_CLUSTERS cells, one cell per cycle while the row
// moves, and each cell keeps its own MAX_FEATURES-deep prototype/weight memory
// and a 48-bit saturating distance accumulator. Every cell adds weight * (feature -
// prototype)^2, shifted right by 16, through a five-stage pipeline (memory read,
// square, weight multiply, accumulate, compare), so the whole row works on consecutive
// transfers at once. The winner search rides the same row: each cell compares its
// finished distance with the running winner from its left neighbor, a tie going to
// the higher index. The result for an object enters the output register once its
// last feature has passed every cell. While a finished result waits in the output
// register and the next result reaches the end of the row, the whole row holds and
// s_axis_tready drops. Tables are undefined after reset until loaded; the accumulators
// and cluster_count (16) are reset. cluster_count is clamped to the range 1 to
// min(MAX_CLUSTERS, 16) and must be written only while the core is idle.
`include "weighted_nearest_centroid_assign_core_defines.svh"

module weighted_nearest_centroid_assign_core #(
    parameter int MAX_CLUSTERS = wnca_pkg::DEF_MAX_CLUSTERS,
    parameter int MAX_FEATURES = wnca_pkg::DEF_MAX_FEATURES
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] cluster_index, [9:4] feature_index, [25:10] value, [41:26] weight,
    // [47:42] zero
    input  logic [47:0] s_axis_tdata,
    // [0] req_type
    input  logic        s_axis_tuser,
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] nearest_cluster, [51:4] min_distance, [55:52] zero
    output logic [55:0] m_axis_tdata
);
    import wnca_pkg::*;

    localparam int COUNT_LIMIT = (MAX_CLUSTERS < OUT_CLUSTERS) ? MAX_CLUSTERS : OUT_CLUSTERS;
    localparam logic REG_CLUSTER_COUNT = 1'b0;

    logic [COUNT_W-1:0] cluster_count_reg;
    logic [COUNT_W-1:0] n_active;
    logic               reg_sel;
    logic               cfg_write;

    tok_t               head_tok;
    best_t              head_best;
    tok_t               tok_link  [MAX_CLUSTERS];
    best_t              best_link [MAX_CLUSTERS];
    best_t              tail;

    logic               advance;
    logic               out_valid_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [ACC_W-1:0]   out_dist_reg;

    // Configuration register. The low address bits select a byte lane and are ignored.
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg <= COUNT_W'(OUT_CLUSTERS);
        end
        else if (cfg_write && reg_sel == REG_CLUSTER_COUNT)
        begin
            cluster_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CLUSTER_COUNT: prdata = 32'(cluster_count_reg);
            default:           prdata = '0;
        endcase
    end

    // Number of clusters that take part in the search.
    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            n_active = COUNT_W'(1);
        end
        else if (32'(cluster_count_reg) > COUNT_LIMIT)
        begin
            n_active = COUNT_W'(COUNT_LIMIT);
        end
        else
        begin
            n_active = cluster_count_reg;
        end
    end

    // The row holds only when a result reaches its end and a full output is not taken.
    assign tail          = best_link[MAX_CLUSTERS-1];
    assign advance       = !(tail.valid && out_valid_reg && !m_axis_tready);
    assign s_axis_tready = advance;

    always_comb
    begin
        head_tok.valid         = s_axis_tvalid;
        head_tok.req_type      = req_t'(s_axis_tuser);
        head_tok.cluster_index = s_axis_tdata[3:0];
        head_tok.feature_index = s_axis_tdata[9:4];
        head_tok.value         = s_axis_tdata[25:10];
        head_tok.weight        = s_axis_tdata[41:26];
        head_tok.last_feature  = s_axis_tlast;
        head_best.valid        = 1'b0;
        head_best.index        = '0;
        head_best.distance     = ACC_MAX;
    end

    for (genvar c = 0; c < MAX_CLUSTERS; c++)
    begin : g_cell
        if (c == 0)
        begin : g_first
            wnca_cell #(
                .CELL         (c),
                .MAX_FEATURES (MAX_FEATURES)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .n_active (n_active),
                .tok_in   (head_tok),
                .best_in  (head_best),
                .tok_out  (tok_link[c]),
                .best_out (best_link[c])
            );
        end
        else
        begin : g_next
            wnca_cell #(
                .CELL         (c),
                .MAX_FEATURES (MAX_FEATURES)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .n_active (n_active),
                .tok_in   (tok_link[c-1]),
                .best_in  (best_link[c-1]),
                .tok_out  (tok_link[c]),
                .best_out (best_link[c])
            );
        end
    end

    // Output register: takes a result from the end of the row whenever the row moves.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && tail.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tail.valid)
        begin
            out_idx_reg  <= tail.index;
            out_dist_reg <= tail.distance;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_dist_reg, out_idx_reg};

    `WNCA_ASSERT_NXT(a_tail_held, tail.valid && out_valid_reg && !m_axis_tready, tail.valid, "result at the end of the row was lost during a stall")
    `WNCA_ASSERT_IMP(a_count_range, 1'b1, n_active != '0 && 32'(n_active) <= COUNT_LIMIT, "cluster count in use out of range")
    `WNCA_ASSERT_NXT(a_cfg_write, cfg_write && reg_sel == REG_CLUSTER_COUNT, cluster_count_reg == $past(pwdata[COUNT_W-1:0]), "cluster count write not taken")

endmodule

// File: verif/tb.sv
// Self-checking testbench for weighted_nearest_centroid_assign_core.
// Streams table loads and object features, predicts each assignment in SystemVerilog
// and compares every result transfer. Depends on wnca_pkg and the core's RTL only.
module tb;
    import wnca_pkg::*;

    localparam int NUM_CLUSTERS  = DEF_MAX_CLUSTERS;
    localparam int NUM_FEATURES  = DEF_MAX_FEATURES;
    localparam int IDLE_PCT      = 17;
    // Time left after the last result for the row to drain, with margin.
    localparam int SETTLE_CYCLES = 2 * (NUM_CLUSTERS + 5) + 10;
    localparam int HOLD_CYCLES   = 500;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SAT_FEATURES  = 24;
    localparam int PHASE_ITEMS   = 105;
    localparam logic [2:0] CLUSTER_COUNT_ADDR = 3'd0;

    // One stream transfer on the slave side, in field form.
    typedef struct {
        req_t        kind;
        logic [3:0]  cluster;
        logic [5:0]  feature;
        logic [15:0] value;
        logic [15:0] weight;
        logic        last;
    } stream_item_t;

    // One assignment result on the master side.
    typedef struct {
        logic [IDX_W-1:0] cluster;
        logic [ACC_W-1:0] distance;
    } assignment_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    weighted_nearest_centroid_assign_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Transfers waiting to be offered, and the assignments predicted but not yet seen.
    stream_item_t pending_transfers[$];
    assignment_t  expected_assignments[$];
    stream_item_t offered;
    bit           in_fire = 1'b0;
    int           mismatches = 0;
    int           queued_count = 0;
    int           cycle_count = 0;

    // Idle control. While quiet is set neither side idles at random. The receiver
    // starts one long hold-off each time stall_asks moves past stall_seen.
    bit quiet = 1'b0;
    int stall_asks = 0;
    int stall_seen = 0;
    int hold_left = 0;

    // Predictor state, updated as transfers are accepted.
    logic [15:0]      proto_mem  [NUM_CLUSTERS][NUM_FEATURES];
    logic [15:0]      weight_mem [NUM_CLUSTERS][NUM_FEATURES];
    logic [ACC_W-1:0] dist_acc   [NUM_CLUSTERS];
    logic [4:0]       count_shadow = 5'd16;

    // Generator bookkeeping. A feature may only stream for a column that every
    // cluster has loaded, since the cells read all clusters' entries for it.
    bit          written       [NUM_CLUSTERS][NUM_FEATURES];
    bit          listed        [NUM_FEATURES];
    logic [15:0] planned_proto [NUM_CLUSTERS][NUM_FEATURES];
    int          ready_cols[$];

    initial
    begin
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            dist_acc[c] = '0;
        end
    end

    // Fold one accepted transfer into the predicted state. A load writes both
    // tables; a feature adds its weighted squared difference into every cluster's
    // saturating accumulator, and the last feature of an object produces the
    // assignment and clears the accumulators.
    task automatic predict_transfer(input stream_item_t it);
        longint signed   diff;
        longint unsigned mag;
        longint unsigned term;
        longint unsigned sum;
        int              in_use;
        assignment_t     best;
        if (it.kind == REQ_LOAD)
        begin
            proto_mem[it.cluster][it.feature] = it.value;
            weight_mem[it.cluster][it.feature] = it.weight;
            return;
        end
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            diff = longint'($signed(it.value)) - longint'($signed(proto_mem[c][it.feature]));
            mag = (diff < 0) ? -diff : diff;
            term = (mag * mag * longint'(weight_mem[c][it.feature])) >> 16;
            sum = longint'(dist_acc[c]) + term;
            dist_acc[c] = (sum > longint'(ACC_MAX)) ? ACC_MAX : sum[ACC_W-1:0];
        end
        if (!it.last)
        begin
            return;
        end
        // The count in use is clamped to 1..16; ties and saturated values go to
        // the higher index because the comparison is less-or-equal.
        in_use = count_shadow;
        if (in_use < 1)
        begin
            in_use = 1;
        end
        if (in_use > NUM_CLUSTERS)
        begin
            in_use = NUM_CLUSTERS;
        end
        best.cluster = '0;
        best.distance = ACC_MAX;
        for (int c = 0; c < in_use; c++)
        begin
            if (dist_acc[c] <= best.distance)
            begin
                best.distance = dist_acc[c];
                best.cluster = c[IDX_W-1:0];
            end
        end
        expected_assignments.push_back(best);
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            dist_acc[c] = '0;
        end
    endtask

    // Sender: inputs change on the falling edge. tvalid stays up with the same
    // item until a transfer happens at a rising edge.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || in_fire)
        begin
            if (pending_transfers.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
            begin
                offered = pending_transfers.pop_front();
                s_axis_tdata  <= {6'b0, offered.weight, offered.value, offered.feature,
                                  offered.cluster};
                s_axis_tuser  <= offered.kind;
                s_axis_tlast  <= offered.last;
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold-off counted here so the
    // core's output register and row fill up and s_axis_tready drops.
    always @(negedge clk)
    begin
        if (stall_asks != stall_seen)
        begin
            stall_seen = stall_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: both handshakes are sampled at the rising edge. Results are checked
    // against the oldest prediction; accepted inputs feed the predictor.
    always @(posedge clk)
    begin : monitor
        assignment_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_assignments.size() == 0)
                begin
                    $display("%0t: unexpected result, cluster %0d distance %0d", $time,
                             m_axis_tdata[3:0], m_axis_tdata[51:4]);
                    mismatches++;
                end
                else
                begin
                    want = expected_assignments.pop_front();
                    if (m_axis_tdata[3:0] !== want.cluster)
                    begin
                        $display("%0t: nearest_cluster expected %0d, got %0d", $time,
                                 want.cluster, m_axis_tdata[3:0]);
                        mismatches++;
                    end
                    if (m_axis_tdata[51:4] !== want.distance)
                    begin
                        $display("%0t: min_distance expected %0d, got %0d", $time,
                                 want.distance, m_axis_tdata[51:4]);
                        mismatches++;
                    end
                end
            end
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire)
            begin
                predict_transfer(offered);
            end
        end
        else
        begin
            in_fire = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[weighted_nearest_centroid_assign_core] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] random_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] random_weight();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit column_ready(input int f);
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            if (!written[c][f])
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // tlast on a load is ignored by the core, so it is random there.
    task automatic push_load(input int c, input int f, input logic [15:0] v,
                             input logic [15:0] w);
        stream_item_t it;
        it.kind    = REQ_LOAD;
        it.cluster = c[3:0];
        it.feature = f[5:0];
        it.value   = v;
        it.weight  = w;
        it.last    = 1'($urandom_range(1));
        pending_transfers.push_back(it);
        queued_count++;
        written[c][f] = 1'b1;
        planned_proto[c][f] = v;
        if (!listed[f] && column_ready(f))
        begin
            listed[f] = 1'b1;
            ready_cols.push_back(f);
        end
    endtask

    // cluster and weight fields are ignored on a feature, so they carry noise.
    task automatic push_feature(input int f, input logic [15:0] v, input bit last);
        stream_item_t it;
        it.kind    = REQ_FEATURE;
        it.cluster = 4'($urandom);
        it.feature = f[5:0];
        it.value   = v;
        it.weight  = 16'($urandom);
        it.last    = last;
        pending_transfers.push_back(it);
        queued_count++;
    endtask

    // Loads one feature column for all clusters. Style 0 is random per cluster,
    // style 1 makes every cluster identical, style 2 makes pairs identical; the
    // last two force equal distances so the tie rule gets exercised.
    task automatic fill_column(input int f, input int style);
        logic [15:0] v;
        logic [15:0] w;
        v = random_value();
        w = random_weight();
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            if (style == 0 || (style == 2 && c % 2 == 0))
            begin
                v = random_value();
                w = random_weight();
            end
            push_load(c, f, v, w);
        end
    endtask

    // An object is a run of features over loaded columns. A quarter of the values
    // copy a cluster's prototype so that small and zero distances show up.
    task automatic push_object(input int len);
        int          f;
        logic [15:0] v;
        for (int i = 0; i < len; i++)
        begin
            f = ready_cols[$urandom_range(ready_cols.size() - 1)];
            if ($urandom_range(3) == 0)
            begin
                v = planned_proto[$urandom_range(NUM_CLUSTERS - 1)][f];
            end
            else
            begin
                v = random_value();
            end
            push_feature(f, v, i == len - 1);
        end
    endtask

    task automatic random_phase(input int target);
        int start;
        int pick;
        int len;
        start = queued_count;
        while (queued_count - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                push_load($urandom_range(NUM_CLUSTERS - 1), $urandom_range(NUM_FEATURES - 1),
                          random_value(), random_weight());
            end
            else if (pick < 20)
            begin
                fill_column($urandom_range(NUM_FEATURES - 1), $urandom_range(2));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    len = $urandom_range(1, 4);
                end
                else if (pick < 95)
                begin
                    len = $urandom_range(5, 12);
                end
                else
                begin
                    len = $urandom_range(13, 40);
                end
                push_object(len);
            end
        end
    endtask

    // Waits until every queued transfer is taken and every result is back, then
    // lets the row drain of transfers that produce no result.
    task automatic wait_idle();
        while (pending_transfers.size() != 0 || s_axis_tvalid || expected_assignments.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: a setup phase, then an access phase held until pready is seen.
    task automatic write_cluster_count(input logic [4:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= CLUSTER_COUNT_ADDR;
        pwdata  <= {27'b0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        count_shadow = v;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Main sequence: load, directed objects, one object of maximal terms, then random
    // phases under a range of cluster counts including the clamped extremes.
    initial
    begin
        int count_plan[8];
        count_plan = '{16, 1, 0, 31, 9, 17, 16, 2};
        count_plan[7] = $urandom_range(2, 15);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Columns 0 and 63 together drive every feature_index bit both ways.
        fill_column(0, 0);
        fill_column(21, 0);
        fill_column(42, 0);
        fill_column(63, 0);

        // Field extremes on loads, including a zero weight.
        push_load(0, 0, 16'h8000, 16'hFFFF);
        push_load(15, 63, 16'h7FFF, 16'hFFFF);
        push_load(7, 0, 16'h0000, 16'h0000);
        push_load(3, 21, 16'h8000, 16'h0000);
        // Single-feature object at the largest difference.
        push_feature(0, 16'h7FFF, 1'b1);
        push_feature(63, 16'h8000, 1'b0);
        push_feature(0, 16'h8000, 1'b0);
        push_feature(21, 16'h0000, 1'b1);
        // Every cluster identical on column 42: a full tie, won by the top index.
        fill_column(42, 1);
        push_feature(42, planned_proto[0][42], 1'b1);
        push_feature(21, planned_proto[9][21], 1'b1);
        push_feature(0, 16'h7FFF, 1'b0);
        push_feature(21, 16'hFFFF, 1'b0);
        push_feature(42, 16'h0001, 1'b0);
        push_feature(63, 16'h0000, 1'b1);
        wait_idle();

        // Largest terms: each feature adds just under 2^32 to every accumulator,
        // so carries run into accumulator bits 32 to 36, and all clusters tie.
        for (int c = 0; c < NUM_CLUSTERS; c++)
        begin
            push_load(c, 5, 16'h7FFF, 16'hFFFF);
        end
        for (int i = 0; i < SAT_FEATURES; i++)
        begin
            push_feature(5, 16'h8000, i == SAT_FEATURES - 1);
        end
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph > 0)
            begin
                write_cluster_count(count_plan[ph][4:0]);
            end
            quiet = (ph == 2);
            random_phase(PHASE_ITEMS);
            wait_idle();
            if (ph == 4)
            begin
                // Long receiver hold-off with the sender offering back to back:
                // many short objects pile up results until the input stalls.
                quiet = 1'b1;
                for (int i = 0; i < 100; i++)
                begin
                    push_object($urandom_range(1, 2));
                end
                stall_asks++;
                wait_idle();
            end
            quiet = 1'b0;
        end

        if (mismatches == 0 && expected_assignments.size() == 0)
        begin
            $display("[weighted_nearest_centroid_assign_core] OK");
        end
        else
        begin
            $display("[weighted_nearest_centroid_assign_core] ERROR");
        end
        $finish;
    end
endmodule
